/* design/tmq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmq_pkg
// Shared types and constants of the timed message queue.
// ----------------------------------------------------------------------------
package tmq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TIME_W  = 48;
    localparam int RCV_W   = 8;
    localparam int MSG_W   = 16;
    localparam int DATA_W  = 32;
    localparam int PAY_W   = RCV_W + MSG_W + DATA_W;
    localparam int DELAY_W = 16;
    localparam int TPM_W   = 11;
    localparam int PROD_W  = DELAY_W + TPM_W;
    localparam int PEND_W  = 5;

    localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(1);

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [TIME_W-1:0] key;
    } t_cell_ctl;

endpackage
`default_nettype wire

/* design/timed_message_queue_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_message_queue_unit
// Delayed-message scheduler built on a sorted row of cells.
// ----------------------------------------------------------------------------
//  channel | handshake                  | carries
//  in      | i_in_valid / o_in_ready    | kind, receiver, message, data, delay
//  out     | o_out_valid / i_out_ready  | delivered, fields, dropped, pending
//  cfg     | i_cfg_we                   | ticks_per_ms
//
//  A request is handled in order: accept with delay*ticks_per_ms multiply,
//  due or next time add, then the cell row update with the result registered.
//  The final step waits while the result register is full and not taken.
//  Synchronous reset clears the count, the time and the control state;
//  ticks_per_ms returns to 1. Cell contents are not cleared.
// ----------------------------------------------------------------------------
module timed_message_queue_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [tmq_pkg::TPM_W-1:0]     i_cfg_wdata,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_kind,
    input  wire [tmq_pkg::RCV_W-1:0]     i_receiver,
    input  wire [tmq_pkg::MSG_W-1:0]     i_message,
    input  wire [tmq_pkg::DATA_W-1:0]    i_extra_data,
    input  wire [tmq_pkg::DELAY_W-1:0]   i_delay,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic                         o_delivered,
    output logic [tmq_pkg::RCV_W-1:0]    o_out_receiver,
    output logic [tmq_pkg::MSG_W-1:0]    o_out_message,
    output logic [tmq_pkg::DATA_W-1:0]   o_out_data,
    output logic                         o_dropped,
    output logic [tmq_pkg::PEND_W-1:0]   o_pending
);

    localparam int CW = tmq_pkg::CNT_W;
    localparam int TW = tmq_pkg::TIME_W;
    localparam int PW = tmq_pkg::PEND_W;
    localparam int RW = tmq_pkg::PROD_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_KEY  = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic                        r_kind;
    logic [tmq_pkg::PAY_W-1:0]   r_pay;
    logic [RW-1:0]               r_prod;
    logic [TW-1:0]               r_key;
    logic [TW-1:0]               r_now;
    logic [CW-1:0]               r_count;
    logic [tmq_pkg::TPM_W-1:0]   r_tpm;
    logic                        r_out_valid;
    logic                        r_delivered;
    logic [tmq_pkg::PAY_W-1:0]   r_out_pay;
    logic                        r_dropped;
    logic [CW-1:0]               r_pend;

    logic                        w_accept;
    logic                        w_go;
    logic                        w_full;
    logic                        w_head_keep;
    logic [tmq_pkg::PAY_W-1:0]   w_head_pay;
    logic [CW-1:0]               n_count;
    tmq_pkg::t_cell_ctl          w_ctl;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_go       = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign w_full     = (r_count == CW'(tmq_pkg::DEPTH));

    always_comb begin
        w_ctl.key = r_key;
        w_ctl.op  = tmq_pkg::OP_HOLD;
        if (w_go) begin
            if (r_kind && !w_full) begin
                w_ctl.op = tmq_pkg::OP_INSERT;
            end else if (!r_kind && w_head_keep) begin
                w_ctl.op = tmq_pkg::OP_POP;
            end
        end
    end

    always_comb begin
        case (w_ctl.op)
            tmq_pkg::OP_INSERT: n_count = r_count + CW'(1);
            tmq_pkg::OP_POP:    n_count = r_count - CW'(1);
            default:            n_count = r_count;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_KEY;
            S_KEY:   n_state = S_EXEC;
            S_EXEC:  if (w_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    tmq_chain u_chain (
        .i_clk          (i_clk),
        .i_ctl          (w_ctl),
        .i_count        (r_count),
        .i_new_payload  (r_pay),
        .o_head_keep    (w_head_keep),
        .o_head_payload (w_head_pay)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_count     <= '0;
            r_tpm       <= tmq_pkg::TPM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_tpm <= i_cfg_wdata;
            end
            if (w_go && !r_kind) begin
                r_now <= r_key;
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_kind;
            r_pay  <= {i_receiver, i_message, i_extra_data};
            r_prod <= RW'(i_delay) * RW'(r_tpm);
        end
        if (r_state == S_KEY) begin
            // tick: next time value; post: due time
            r_key <= r_kind ? (r_now + TW'(r_prod)) : (r_now + TW'(1));
        end
        if (w_go) begin
            r_delivered <= (w_ctl.op == tmq_pkg::OP_POP);
            r_out_pay   <= (w_ctl.op == tmq_pkg::OP_POP) ? w_head_pay : '0;
            r_dropped   <= r_kind && w_full;
            r_pend      <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_delivered    = r_delivered;
    assign o_out_receiver = r_out_pay[tmq_pkg::PAY_W-1 -: tmq_pkg::RCV_W];
    assign o_out_message  = r_out_pay[tmq_pkg::DATA_W +: tmq_pkg::MSG_W];
    assign o_out_data     = r_out_pay[tmq_pkg::DATA_W-1:0];
    assign o_dropped      = r_dropped;
    assign o_pending      = PW'(r_pend);

endmodule
`default_nettype wire

/* design/tmq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmq_cell
// One slot of the sorted store: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module tmq_cell (
    input  wire                           i_clk,
    input  wire tmq_pkg::t_cell_ctl       i_ctl,
    input  wire                           i_occupied,
    input  wire [tmq_pkg::PAY_W-1:0]      i_new_payload,
    input  wire                           i_left_keep,
    input  wire [tmq_pkg::TIME_W-1:0]     i_left_due,
    input  wire [tmq_pkg::PAY_W-1:0]      i_left_payload,
    input  wire [tmq_pkg::TIME_W-1:0]     i_right_due,
    input  wire [tmq_pkg::PAY_W-1:0]      i_right_payload,
    output logic                          o_keep,
    output logic [tmq_pkg::TIME_W-1:0]    o_due,
    output logic [tmq_pkg::PAY_W-1:0]     o_payload
);

    logic [tmq_pkg::TIME_W-1:0] r_due;
    logic [tmq_pkg::PAY_W-1:0]  r_payload;
    logic [tmq_pkg::TIME_W-1:0] n_due;
    logic [tmq_pkg::PAY_W-1:0]  n_payload;

    // entry stays in place on insert when it is due no later than the new one
    assign o_keep    = i_occupied && (r_due <= i_ctl.key);
    assign o_due     = r_due;
    assign o_payload = r_payload;

    always_comb begin
        n_due     = r_due;
        n_payload = r_payload;
        case (i_ctl.op)
            tmq_pkg::OP_INSERT: begin
                if (!o_keep) begin
                    if (i_left_keep) begin
                        n_due     = i_ctl.key;
                        n_payload = i_new_payload;
                    end else begin
                        n_due     = i_left_due;
                        n_payload = i_left_payload;
                    end
                end
            end
            tmq_pkg::OP_POP: begin
                n_due     = i_right_due;
                n_payload = i_right_payload;
            end
            default: begin
                n_due     = r_due;
                n_payload = r_payload;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_due     <= n_due;
        r_payload <= n_payload;
    end

endmodule
`default_nettype wire

/* design/tmq_chain.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmq_chain
// Row of cells kept sorted by due time; cell 0 is the head.
// ----------------------------------------------------------------------------
module tmq_chain (
    input  wire                           i_clk,
    input  wire tmq_pkg::t_cell_ctl       i_ctl,
    input  wire [tmq_pkg::CNT_W-1:0]      i_count,
    input  wire [tmq_pkg::PAY_W-1:0]      i_new_payload,
    output logic                          o_head_keep,
    output logic [tmq_pkg::PAY_W-1:0]     o_head_payload
);

    logic                       w_keep    [tmq_pkg::DEPTH];
    logic [tmq_pkg::TIME_W-1:0] w_due     [tmq_pkg::DEPTH];
    logic [tmq_pkg::PAY_W-1:0]  w_payload [tmq_pkg::DEPTH];

    genvar g;
    generate
        for (g = 0; g < tmq_pkg::DEPTH; g++) begin : g_cell
            logic                       w_occ;
            logic                       w_lkeep;
            logic [tmq_pkg::TIME_W-1:0] w_ldue;
            logic [tmq_pkg::PAY_W-1:0]  w_lpay;
            logic [tmq_pkg::TIME_W-1:0] w_rdue;
            logic [tmq_pkg::PAY_W-1:0]  w_rpay;

            assign w_occ = (tmq_pkg::CNT_W'(g) < i_count);

            if (g == 0) begin : g_first
                assign w_lkeep = 1'b1;
                assign w_ldue  = i_ctl.key;
                assign w_lpay  = i_new_payload;
            end else begin : g_mid
                assign w_lkeep = w_keep[g-1];
                assign w_ldue  = w_due[g-1];
                assign w_lpay  = w_payload[g-1];
            end

            if (g == tmq_pkg::DEPTH - 1) begin : g_last
                assign w_rdue = w_due[g];
                assign w_rpay = w_payload[g];
            end else begin : g_inner
                assign w_rdue = w_due[g+1];
                assign w_rpay = w_payload[g+1];
            end

            tmq_cell u_cell (
                .i_clk           (i_clk),
                .i_ctl           (i_ctl),
                .i_occupied      (w_occ),
                .i_new_payload   (i_new_payload),
                .i_left_keep     (w_lkeep),
                .i_left_due      (w_ldue),
                .i_left_payload  (w_lpay),
                .i_right_due     (w_rdue),
                .i_right_payload (w_rpay),
                .o_keep          (w_keep[g]),
                .o_due           (w_due[g]),
                .o_payload       (w_payload[g])
            );
        end
    endgenerate

    assign o_head_keep    = w_keep[0];
    assign o_head_payload = w_payload[0];

endmodule
`default_nettype wire
